// ===== rtl/reed_solomon_syndrome_calc_unit_assert.svh =====
// assertion macros for the reed-solomon syndrome block
// needs clk and rst_n in the scope of each use
`ifndef REED_SOLOMON_SYNDROME_CALC_UNIT_ASSERT_SVH
`define REED_SOLOMON_SYNDROME_CALC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define RSSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rssc assertion failed");

`define RSSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rssc assertion failed");

`else

`define RSSC_ASSERT(lbl, prop)

`define RSSC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/rssc_pkg.sv =====
// shared constants, types and gf(256) helpers for the syndrome block
// no dependencies
`default_nettype none

package rssc_pkg;

  localparam int MAX_SYNDROMES = 32;
  localparam int FIELD_POLY    = 285;
  localparam int IDX_W         = (MAX_SYNDROMES > 1) ? $clog2(MAX_SYNDROMES) : 1;
  localparam int CNT_W         = 7;
  localparam int SYN_IDX_W     = 6;
  localparam int BYTE_W        = 8;

  localparam logic [BYTE_W-1:0] POLY_LOW = BYTE_W'(FIELD_POLY);

  typedef struct packed {
    logic update;
    logic load_first;
    logic load_next;
    logic clear;
  } rssc_cmd_t;

  typedef struct packed {
    logic is_last;
  } rssc_sts_t;

  function automatic logic [BYTE_W-1:0] times_alpha(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    r = {v[BYTE_W-2:0], 1'b0};
    if (v[BYTE_W-1]) begin
      r = r ^ POLY_LOW;
    end
    return r;
  endfunction

  // elaboration only: power is a constant per lane
  function automatic logic [BYTE_W-1:0] alpha_pow(input int power);
    logic [BYTE_W-1:0] r;
    r = BYTE_W'(1);
    for (int k = 0; k < power; k++) begin
      r = times_alpha(r);
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] p;
    logic [BYTE_W-1:0] x;
    p = '0;
    x = a;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b[k]) begin
        p = p ^ x;
      end
      x = times_alpha(x);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rssc_ctrl.sv =====
// controller: takes bytes, then sequences the syndrome beats out
// depends on rssc_pkg and the assertion macro header
`default_nettype none
`include "reed_solomon_syndrome_calc_unit_assert.svh"

module rssc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_block_end,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rssc_pkg::rssc_cmd_t    cmd,
  input  wire rssc_pkg::rssc_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_SEND = 3'b100
  } rssc_state_t;

  rssc_state_t state_r;
  rssc_state_t state_nxt;
  logic        in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.update     = in_acc;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_block_end) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_first = 1'b1;
        state_nxt      = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall) begin
          if (sts.is_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.load_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RSSC_ASSERT(a_no_input_while_sending, out_valid |-> in_stall)
  `RSSC_ASSERT(a_end_byte_starts_run,
    (in_valid && !in_stall && in_block_end) |=> ##1 out_valid)
  `RSSC_ASSERT(a_run_stops_after_last,
    (out_valid && !out_stall && sts.is_last) |=> (!out_valid && !in_stall))
  `RSSC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid)

endmodule

`default_nettype wire

// ===== rtl/rssc_datapath.sv =====
// datapath: per-syndrome gf(256) accumulator lanes, count register, output register
// depends on rssc_pkg
`default_nettype none

module rssc_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [rssc_pkg::CNT_W-1:0]      cfg_wr_data,
  input  wire logic [rssc_pkg::BYTE_W-1:0]     in_data_byte,
  input  wire rssc_pkg::rssc_cmd_t             cmd,
  output rssc_pkg::rssc_sts_t                  sts,
  output logic [rssc_pkg::SYN_IDX_W-1:0]       out_syndrome_index,
  output logic [rssc_pkg::BYTE_W-1:0]          out_syndrome_value,
  output logic                                 out_run_end,
  output logic                                 out_error_free
);

  localparam int NS  = rssc_pkg::MAX_SYNDROMES;
  localparam int IW  = rssc_pkg::IDX_W;
  localparam int CW  = rssc_pkg::CNT_W;
  localparam int BW  = rssc_pkg::BYTE_W;

  logic [CW-1:0] count_r;
  logic [IW-1:0] last_idx;

  logic [BW-1:0] acc_r   [NS];
  logic [BW-1:0] acc_nxt [NS];
  logic [NS-1:0] nz_r;
  logic [NS-1:0] lane_on;

  logic [IW-1:0] idx_r;
  logic [BW-1:0] value_r;
  logic          run_end_r;
  logic          error_free_r;

  logic [IW-1:0] rd_idx;
  logic          any_nz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(32);
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // zero counts as one, anything above the lane count saturates
  always_comb begin
    priority if (count_r == '0) begin
      last_idx = '0;
    end else if (count_r > CW'(NS)) begin
      last_idx = IW'(NS - 1);
    end else begin
      last_idx = IW'(count_r - CW'(1));
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_lane
    localparam logic [BW-1:0] ALPHA_I = rssc_pkg::alpha_pow(i);

    always_comb begin
      acc_nxt[i] = in_data_byte ^ rssc_pkg::gf_mul(acc_r[i], ALPHA_I);
      lane_on[i] = (IW'(i) <= last_idx);
    end

    always_ff @(posedge clk) begin
      if (!rst_n || cmd.clear) begin
        acc_r[i] <= '0;
        nz_r[i]  <= 1'b0;
      end else if (cmd.update) begin
        acc_r[i] <= acc_nxt[i];
        nz_r[i]  <= |acc_nxt[i];
      end
    end
  end

  assign any_nz = |(nz_r & lane_on);
  assign rd_idx = cmd.load_first ? '0 : IW'(idx_r + IW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_first || cmd.load_next) begin
      idx_r     <= rd_idx;
      value_r   <= acc_r[rd_idx];
      run_end_r <= (rd_idx == last_idx);
    end
    if (cmd.load_first) begin
      error_free_r <= !any_nz;
    end
  end

  assign sts.is_last         = run_end_r;
  assign out_syndrome_index  = rssc_pkg::SYN_IDX_W'(idx_r);
  assign out_syndrome_value  = value_r;
  assign out_run_end         = run_end_r;
  assign out_error_free      = error_free_r;

endmodule

`default_nettype wire

// ===== rtl/reed_solomon_syndrome_calc_unit.sv =====
// reed-solomon syndrome unit over gf(256): one codeword byte per cycle while in_stall
// is low. after the end-of-block byte the controller passes through ST_LOAD, which
// fills the output register, before the first syndrome beat is offered; then one beat
// per cycle while out_stall is low; a single output register walks the accumulator lanes.
// synchronous reset: count goes to 32, accumulators clear, no beat pending.
// depends on rssc_pkg, rssc_ctrl and rssc_datapath
`default_nettype none

module reed_solomon_syndrome_calc_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rssc_pkg::CNT_W-1:0]        cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rssc_pkg::BYTE_W-1:0]       in_data_byte,
  input  wire logic                              in_block_end,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rssc_pkg::SYN_IDX_W-1:0]         out_syndrome_index,
  output logic [rssc_pkg::BYTE_W-1:0]            out_syndrome_value,
  output logic                                   out_run_end,
  output logic                                   out_error_free
);

  rssc_pkg::rssc_cmd_t cmd;
  rssc_pkg::rssc_sts_t sts;

  rssc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_block_end (in_block_end),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  rssc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_data_byte       (in_data_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_syndrome_index (out_syndrome_index),
    .out_syndrome_value (out_syndrome_value),
    .out_run_end        (out_run_end),
    .out_error_free     (out_error_free)
  );

endmodule

`default_nettype wire
